// File: rtl/bepe_pkg.sv
// ----------------------------------------------------------------------------
// bepe_pkg
// Shared constants and types for the binary edge pixel extractor.
// ----------------------------------------------------------------------------
package bepe_pkg;

  // Line memory depth: longest supported image row
  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = 16;

  // Configuration register widths
  localparam int unsigned CFG_WIDTH_W  = 13;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_THR_W    = 4;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_OUTSIDE  = 2'd2;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(480);
  localparam logic [CFG_THR_W-1:0]    THR_RST    = CFG_THR_W'(1);

  // Line memory word: bit 0 = row r-2, bit 1 = row r-1
  localparam int unsigned LINE_W = 2;

  typedef struct packed {
    logic [COL_W-1:0] edge_x;
    logic [ROW_W-1:0] edge_y;
    logic             is_edge;
    logic             frame_end;
  } bepe_result_t;

endpackage

// File: rtl/bepe_ram.sv
// ----------------------------------------------------------------------------
// bepe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bepe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/binary_edge_pixel_extractor_core.sv
// ----------------------------------------------------------------------------
// binary_edge_pixel_extractor_core
// 3x3 boundary pixel extraction on a raster-order binary pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output keeps up. The two previous rows
// live in one 4096 x 2 line memory, read in the transfer cycle and written back
// the cycle after. A pixel's result (if any) passes through the stage 1
// registers and is written into a two-entry result buffer, which drives the
// output. in_stall_o rises whenever the buffer plus the pixel in stage 1 could
// overrun it, and it also follows out_stall_i combinationally. While a result
// waits, no pixel is taken while another is in stage 1, and none are taken
// once both entries are full. After reset every line memory word is cleared,
// during which in_stall_o is high; configuration writes are taken at any time.
module binary_edge_pixel_extractor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pixel_on_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bepe_pkg::COL_W-1:0]          edge_x_o,
  output logic [bepe_pkg::ROW_W-1:0]          edge_y_o,
  output logic                                is_edge_o,
  output logic                                frame_end_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bepe_pkg::APB_AW-1:0]         paddr,
  input  logic [bepe_pkg::APB_DW-1:0]         pwdata,
  output logic [bepe_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  import bepe_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [CFG_THR_W-1:0]    cfg_thr_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_thr_q    <= THR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[CFG_HEIGHT_W-1:0];
        REG_MIN_OUTSIDE:  cfg_thr_q    <= pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_height_q);
      REG_MIN_OUTSIDE:  prdata = APB_DW'(cfg_thr_q);
      default:          prdata = '0;
    endcase
  end

  // clamped frame geometry
  logic [CFG_WIDTH_W-1:0]  w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (cfg_width_q < CFG_WIDTH_W'(3)) begin
      w_eff = CFG_WIDTH_W'(3);
    end else if (cfg_width_q > CFG_WIDTH_W'(MAX_WIDTH)) begin
      w_eff = CFG_WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_width_q;
    end
    h_eff = (cfg_height_q < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : cfg_height_q;
  end

  // --------------------------------------------------------------------------
  // Line memory clear after reset
  // --------------------------------------------------------------------------
  logic [COL_W:0] clr_cnt_q;
  logic           clearing;

  assign clearing = !clr_cnt_q[COL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: transfer, position counters, line memory read
  // --------------------------------------------------------------------------
  logic             in_xfer;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             row_end, frame_last, judge;

  assign in_xfer = in_valid_i && !in_stall_o;

  always_comb begin
    row_end    = {1'b0, col_q} >= (w_eff - CFG_WIDTH_W'(1));
    frame_last = row_end && (row_q >= (h_eff - ROW_W'(1)));
    judge      = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) &&
                 (row_q <= (h_eff - ROW_W'(1)));
    if (row_end) begin
      col_d = '0;
      row_d = frame_last ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers
  logic             s1_valid_q;
  logic             s1_px_q, s1_judge_q, s1_last_q;
  logic [COL_W-1:0] s1_idx_q, s1_x_q;
  logic [ROW_W-1:0] s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_px_q    <= pixel_on_i;
      s1_judge_q <= judge;
      s1_last_q  <= frame_last;
      s1_idx_q   <= col_q;
      s1_x_q     <= col_q - 1'b1;
      s1_y_q     <= row_q - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: read at transfer, write back in stage 1. Consecutive pixels
  // always use different columns, so the read never sees a pending write.
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [LINE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q[COL_W-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_q;
      ram_waddr = s1_idx_q;
      ram_wdata = {s1_px_q, ram_rdata[1]};  // middle row moves up
    end
  end

  bepe_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: window shift and neighbor test
  // --------------------------------------------------------------------------
  logic [8:0]           win_q, win_d;
  logic [7:0]           nbrs;
  logic [3:0]           ones, clear_cnt;
  logic                 is_edge, push;
  bepe_result_t         res;

  always_comb begin
    win_d = {s1_px_q, ram_rdata[1], ram_rdata[0], win_q[8:3]};
    nbrs  = {win_d[8:5], win_d[3:0]};
    ones  = '0;
    for (int k = 0; k < 8; k++) begin
      ones = ones + 4'(nbrs[k]);
    end
    clear_cnt = 4'd8 - ones;
    is_edge   = s1_judge_q && win_d[4] && (clear_cnt >= cfg_thr_q);
    push      = s1_valid_q && (is_edge || s1_last_q);

    res.edge_x    = is_edge ? s1_x_q : '0;
    res.edge_y    = is_edge ? s1_y_q : '0;
    res.is_edge   = is_edge;
    res.frame_end = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer, two entries. Input is taken only when the item in stage 1
  // and the new one are both sure of a slot.
  // --------------------------------------------------------------------------
  bepe_result_t buf_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         pop;
  logic [2:0]   occ;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign occ         = 3'(cnt_q) + 3'(s1_valid_q) - 3'(pop);
  assign in_stall_o  = clearing || (occ > 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  assign edge_x_o    = buf_q[rd_ptr_q].edge_x;
  assign edge_y_o    = buf_q[rd_ptr_q].edge_y;
  assign is_edge_o   = buf_q[rd_ptr_q].is_edge;
  assign frame_end_o = buf_q[rd_ptr_q].frame_end;

endmodule

// File: rtl/bepe_checker.sv
// ----------------------------------------------------------------------------
// bepe_checker
// Port-level checks for the binary edge pixel extractor, bound to the core.
// ----------------------------------------------------------------------------
module bepe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bepe_pkg::COL_W-1:0]  edge_x_o,
  input logic [bepe_pkg::ROW_W-1:0]  edge_y_o,
  input logic                        is_edge_o,
  input logic                        frame_end_o
);

  import bepe_pkg::*;

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_x_o) &&
    $stable(edge_y_o) && $stable(is_edge_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // a result is an edge, a frame end, or both
  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_edge_o || frame_end_o)
    else $error("result with neither edge nor frame end");

  // frame end without an edge carries zero coordinates
  a_no_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_edge_o |-> edge_x_o == '0 && edge_y_o == '0)
    else $error("non-edge result with nonzero coordinates");

  // row 0 and column 0 are never reported
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_edge_o |-> edge_x_o != '0 && edge_y_o != '0)
    else $error("edge reported on the border");

endmodule

bind binary_edge_pixel_extractor_core bepe_checker u_bepe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .edge_x_o    (edge_x_o),
  .edge_y_o    (edge_y_o),
  .is_edge_o   (is_edge_o),
  .frame_end_o (frame_end_o)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_edge_pixel_extractor_core: raster pixel
// frames go in over the valid/stall port, and every transfer is also applied
// to a bit-accurate boundary predictor in the bench. Each output transfer is
// checked field by field against the oldest predicted result. Registers are
// set over APB between phases and read back each time.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bepe_pkg::*;

  localparam int DRAIN_CYCLES  = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int WIDE_ITEMS    = 200;
  localparam int RANDOM_ITEMS  = 950;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              pixel_on_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [COL_W-1:0]  edge_x_o;
  logic [ROW_W-1:0]  edge_y_o;
  logic              is_edge_o;
  logic              frame_end_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state and register copies
  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [CFG_THR_W-1:0]    cfg_thr;
  logic [MAX_WIDTH-1:0]    line_upper;
  logic [MAX_WIDTH-1:0]    line_middle;
  logic [8:0]              win_bits;
  logic [COL_W-1:0]        col_cnt;
  logic [ROW_W-1:0]        row_cnt;
  bepe_result_t            pending_edges[$];

  int mismatch_count = 0;
  int stall_pct      = 0;
  int gap_max        = 0;
  int hold_len       = 0;
  int burst_left     = 0;

  binary_edge_pixel_extractor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_on_i  (pixel_on_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .edge_x_o    (edge_x_o),
    .edge_y_o    (edge_y_o),
    .is_edge_o   (is_edge_o),
    .frame_end_o (frame_end_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // One pixel into the boundary predictor; queues the result it causes, if any.
  task automatic predict_boundary(input logic px);
    int unsigned w;
    int unsigned h;
    int unsigned nclear;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic hit;
    logic last;
    bepe_result_t res;
    w = (cfg_width < 3) ? 3 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = (cfg_height < 3) ? 3 : cfg_height;
    c = col_cnt;
    r = row_cnt;
    // new right column: top = row r-2, middle = row r-1, bottom = incoming
    win_bits = {px, line_middle[c], line_upper[c], win_bits[8:3]};
    line_upper[c] = line_middle[c];
    line_middle[c] = px;
    hit = 1'b0;
    if (c >= 2 && r >= 2 && r <= h - 1 && win_bits[4]) begin
      nclear = 0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4 && !win_bits[k]) nclear++;
      end
      hit = (nclear >= cfg_thr);
    end
    last = (c >= w - 1) && (r >= h - 1);
    if (c >= w - 1) begin
      col_cnt = '0;
      row_cnt = last ? '0 : r + 1'b1;
    end else begin
      col_cnt = c + 1'b1;
    end
    if (hit || last) begin
      res.edge_x    = hit ? c - 1'b1 : '0;
      res.edge_y    = hit ? r - 1'b1 : '0;
      res.is_edge   = hit;
      res.frame_end = last;
      pending_edges = {pending_edges, res};
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Register copies, pixel transfers and result transfers, all seen at the edge.
  always @(posedge clk_i) begin : monitor
    bepe_result_t want;
    if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  cfg_width  = pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height = pwdata[CFG_HEIGHT_W-1:0];
        REG_MIN_OUTSIDE:  cfg_thr    = pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_o) predict_boundary(pixel_on_i);
    if (out_valid_o && !out_stall_i) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d is_edge=%0b frame_end=%0b",
                 $time, edge_x_o, edge_y_o, is_edge_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = pending_edges.pop_front();
        check_field("edge_x", want.edge_x, edge_x_o);
        check_field("edge_y", want.edge_y, edge_y_o);
        check_field("is_edge", want.is_edge, is_edge_o);
        check_field("frame_end", want.frame_end, frame_end_o);
      end
    end
  end

  // Output side: random stall runs, or one long hold when a test asks for it.
  initial begin : receiver
    int run;
    out_stall_i = 1'b0;
    forever begin
      if (hold_len > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        run = $urandom_range(1, 12);
        @(negedge clk_i);
        out_stall_i = ($urandom_range(0, 99) < stall_pct);
        repeat (run - 1) @(negedge clk_i);
      end
    end
  end

  // Sends one pixel; the sender runs in bursts with random idle gaps between.
  task automatic send_pixel(input logic px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        pixel_on_i = $urandom_range(0, 1);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pixel_on_i = px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_window(input logic [8:0] bits);
    for (int k = 0; k < 9; k++) send_pixel(bits[k]);
  endtask

  // Stop sending and wait for every predicted result, then let the pipeline settle.
  task automatic wait_idle();
    int guard;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    guard = 0;
    while (pending_edges.size() != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_edges.size() != 0) begin
      $display("%0t: %0d results never arrived, next x=%0d y=%0d", $time,
               pending_edges.size(), pending_edges[0].edge_x, pending_edges[0].edge_y);
      mismatch_count++;
      pending_edges.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'({idx, 2'b00});
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = APB_AW'({idx, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      $display("%0t: register %0d read expected %0d got %0d", $time, idx, want, got);
      mismatch_count++;
    end
  endtask

  task automatic set_regs(input logic [APB_DW-1:0] w, input logic [APB_DW-1:0] h,
                          input logic [APB_DW-1:0] thr);
    wait_idle();
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    apb_write(REG_MIN_OUTSIDE, thr);
    check_reg(REG_IMAGE_WIDTH, APB_DW'(cfg_width));
    check_reg(REG_IMAGE_HEIGHT, APB_DW'(cfg_height));
    check_reg(REG_MIN_OUTSIDE, APB_DW'(cfg_thr));
  endtask

  task automatic test_register_defaults();
    check_reg(REG_IMAGE_WIDTH, APB_DW'(WIDTH_RST));
    check_reg(REG_IMAGE_HEIGHT, APB_DW'(HEIGHT_RST));
    check_reg(REG_MIN_OUTSIDE, APB_DW'(THR_RST));
  endtask

  // 3x3 frames: one judged centre, whose result is also the frame-end transfer.
  task automatic test_directed_windows();
    stall_pct = 30;
    gap_max   = 3;
    // width and height below range act as 3; zero threshold reports any set pixel
    set_regs(0, 0, 0);
    send_window(9'b111_111_111);
    // lone pixel: all 8 neighbors clear meets the top threshold
    set_regs(3, 3, 8);
    send_window(9'b000_010_000);
    // threshold past 8 is never met: frame end without an edge
    set_regs(2, 1, 15);
    send_window(9'b000_010_000);
  endtask

  // Width register past the line length: a long row that does not end early,
  // left open so the next, narrower width has to end it at once.
  task automatic test_widest_row();
    stall_pct = 10;
    gap_max   = 2;
    set_regs(8191, 3, 1);
    repeat (WIDE_ITEMS) send_pixel($urandom_range(0, 99) < 4);
  endtask

  // Shrink width mid-row, then height mid-frame: counters past the new bounds.
  task automatic test_bound_change();
    stall_pct = 20;
    gap_max   = 4;
    set_regs(12, 10, 2);
    repeat (67) send_pixel($urandom_range(0, 99) < 60);
    set_regs(4, 10, 2);
    repeat (8) send_pixel($urandom_range(0, 99) < 60);
    set_regs(4, 3, 2);
    repeat (13) send_pixel($urandom_range(0, 99) < 60);
  endtask

  // Long output hold while dense results keep coming: the input must stall.
  task automatic test_output_hold();
    set_regs(8, 8, 0);
    stall_pct = 0;
    gap_max   = 0;
    hold_len  = HOLD_CYCLES;
    repeat (4 * 64) send_pixel(1'b1);
    wait_idle();
  endtask

  // Tallest frame; leaves the row counter far past the later, smaller heights.
  task automatic test_tallest_frame();
    stall_pct = 25;
    gap_max   = 4;
    set_regs(3, 65535, 3);
    repeat (300) send_pixel($urandom_range(0, 99) < 50);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned thr;
    int unsigned weff;
    int unsigned heff;
    int unsigned n;
    int unsigned density;
    int unsigned nframes;
    int unsigned items;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(25, 64);
        default: w = $urandom_range(3, 24);
      endcase
      h   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      thr = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 15);
      stall_pct = 20 * $urandom_range(0, 3);
      gap_max   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
      set_regs(w, h, thr);
      weff = (w < 3) ? 3 : w;
      heff = (h < 3) ? 3 : h;
      // first frame finishes whatever the counters hold, so later ones line up
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        if (f > 0 && items >= RANDOM_ITEMS) break;
        if (f == 0) begin
          n = (col_cnt >= weff - 1) ? 1 : weff - col_cnt;
          if (row_cnt < heff - 1) n += (heff - 1 - row_cnt) * weff;
        end else begin
          n = weff * heff;
        end
        density = 3 + 23 * $urandom_range(0, 4);
        repeat (n) send_pixel($urandom_range(0, 99) < density);
        items += n;
      end
      // occasionally leave a frame cut short
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, weff * heff - 1);
        repeat (n) send_pixel($urandom_range(0, 1));
        items += n;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_on_i  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_width   = WIDTH_RST;
    cfg_height  = HEIGHT_RST;
    cfg_thr     = THR_RST;
    line_upper  = '0;
    line_middle = '0;
    win_bits    = '0;
    col_cnt     = '0;
    row_cnt     = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_defaults();
    test_directed_windows();
    test_widest_row();
    test_bound_change();
    test_output_hold();
    test_tallest_frame();
    test_random_frames();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule
